// File: hdl/kwm_pkg.sv
// Package for the k-way merge selector: sizes, codes and the sequencer state type.
// No dependencies; used by k_way_merge_selector.
`default_nettype none

package kwm_pkg;

    localparam int WAYS  = 8;
    localparam int DEPTH = 16;

    // Field widths fixed by the stream format.
    localparam int CMD_W    = 1;
    localparam int WAYF_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 4;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Derived sizes.
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W  = $clog2(WAYS + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int WX_W   = ((WAY_W > WAYF_W) ? WAY_W : WAYF_W) + 1;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int ADDR_W = $clog2(WAYS * DEPTH);

    localparam logic [CFG_W-1:0] WAYS_IN_USE_RESET = CFG_W'(8);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        REG_WAYS_IN_USE = 1'b0,
        REG_UNUSED      = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: hdl/k_way_merge_selector.sv
// K-way merge selector: per-way FIFOs in one shared memory and a sequential head scan.
// Depends on kwm_pkg.
`default_nettype none

// Each of WAYS ways holds a FIFO of up to DEPTH signed 32-bit values in one
// shared memory. A push (tuser cmd 0) appends a value to a way and answers
// with status full when the way has no room; a pop (cmd 1) scans the heads of
// the non-empty ways below ways_in_use, one memory read and one signed compare
// per cycle, and returns the smallest head with its way, the lowest way
// winning a tie, or status empty. The block takes one item at a time and
// accepts no new item until it is back in the idle state. The scan is paced
// by the single read port of the way memory feeding the one comparator,
// whose compare of each head comes in the cycle after its read. A
// finished result sits in the output register while the next item is taken;
// a new result that finds that register still waiting on m_tready holds the
// block in its done state until the register is free. Configuration is to be
// written over APB only while idle; the block itself does not enforce this.
module k_way_merge_selector (
    input  wire                           clk,
    input  wire                           rst_n,
    // Input stream.
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [kwm_pkg::IN_DATA_W-1:0] s_tdata,   // way[2:0], value[34:3], zero fill
    input  wire  [kwm_pkg::CMD_W-1:0]     s_tuser,   // cmd[0]
    // Result stream.
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [kwm_pkg::OUT_DATA_W-1:0] m_tdata,  // smallest_value[31:0], source_way[34:32]
    output logic [kwm_pkg::STATUS_W-1:0]  m_tuser,   // status[1:0]
    // Configuration.
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [kwm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire  [kwm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kwm_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import kwm_pkg::*;

    // Way memory.
    logic [VALUE_W-1:0] way_store [WAYS*DEPTH];
    logic [VALUE_W-1:0] mem_q_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;

    // Per-way FIFO control.
    logic [PTR_W-1:0]  rp_reg   [WAYS];
    logic [PTR_W-1:0]  rp_next  [WAYS];
    logic [FILL_W-1:0] fc_reg   [WAYS];
    logic [FILL_W-1:0] fc_next  [WAYS];

    logic [CFG_W-1:0] ways_in_use_reg;

    state_t state_reg, state_next;

    // Scan registers.
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pipe_vld_reg, pipe_vld_next;
    logic [WAY_W-1:0]   pipe_way_reg, pipe_way_next;
    logic               found_reg, found_next;
    logic [VALUE_W-1:0] best_val_reg, best_val_next;
    logic [WAY_W-1:0]   best_way_reg, best_way_next;

    // Finished result and output register.
    status_t            res_status_reg, res_status_next;
    logic [VALUE_W-1:0] res_val_reg, res_val_next;
    logic [WAYF_W-1:0]  res_way_reg, res_way_next;
    logic               out_vld_reg, out_vld_next;
    status_t            out_status_reg;
    logic [VALUE_W-1:0] out_val_reg;
    logic [WAYF_W-1:0]  out_way_reg;
    logic               load_out;

    // Input fields.
    cmd_t               in_cmd;
    logic [WAYF_W-1:0]  in_way;
    logic [VALUE_W-1:0] in_value;
    logic               accept;
    logic [WX_W-1:0]    way_x;
    logic [WAY_W-1:0]   wi;
    logic               way_ok;
    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   tail;
    logic [CMP_W-1:0]   n_ways;
    logic               scan_more;
    logic [WAY_W-1:0]   idx_i;
    logic               cfg_wr;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_way   = s_tdata[WAYF_W-1:0];
    assign in_value = s_tdata[WAYF_W+VALUE_W-1:WAYF_W];
    assign accept   = s_tvalid && s_tready;

    assign way_x  = WX_W'(in_way);
    assign wi     = way_x[WAY_W-1:0];
    assign way_ok = way_x < WX_W'(WAYS);

    // Tail slot of the addressed way; the sum stays below twice DEPTH.
    always_comb
    begin
        tail_sum = SUM_W'(rp_reg[wi]) + SUM_W'(fc_reg[wi]);
        if (tail_sum >= SUM_W'(DEPTH))
        begin
            tail_sum = tail_sum - SUM_W'(DEPTH);
        end
        tail = tail_sum[PTR_W-1:0];
    end

    assign n_ways = (CMP_W'(ways_in_use_reg) > CMP_W'(WAYS)) ? CMP_W'(WAYS)
                                                              : CMP_W'(ways_in_use_reg);
    assign scan_more = CMP_W'(idx_reg) < n_ways;
    assign idx_i     = idx_reg[WAY_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_cmd == CMD_PUSH) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!scan_more && !pipe_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and handshake outputs.
    always_comb
    begin
        s_tready        = (state_reg == ST_IDLE);
        load_out        = (state_reg == ST_DONE) && (!out_vld_reg || m_tready);
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_raddr       = '0;
        rp_next         = rp_reg;
        fc_next         = fc_reg;
        idx_next        = idx_reg;
        pipe_vld_next   = 1'b0;
        pipe_way_next   = pipe_way_reg;
        found_next      = found_reg;
        best_val_next   = best_val_reg;
        best_way_next   = best_way_reg;
        res_status_next = res_status_reg;
        res_val_next    = res_val_reg;
        res_way_next    = res_way_reg;

        if (load_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_val_next = '0;
                    res_way_next = '0;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    if (in_cmd == CMD_PUSH)
                    begin
                        if (way_ok && (fc_reg[wi] != FILL_W'(DEPTH)))
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = ADDR_W'(wi) * ADDR_W'(DEPTH) + ADDR_W'(tail);
                            fc_next[wi]     = fc_reg[wi] + FILL_W'(1);
                            res_status_next = STAT_OK;
                        end
                        else
                        begin
                            res_status_next = STAT_FULL;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // Compare the head read in the previous cycle.
                if (pipe_vld_reg &&
                    (!found_reg || ($signed(mem_q_reg) < $signed(best_val_reg))))
                begin
                    found_next    = 1'b1;
                    best_val_next = mem_q_reg;
                    best_way_next = pipe_way_reg;
                end
                if (scan_more)
                begin
                    mem_raddr     = ADDR_W'(idx_i) * ADDR_W'(DEPTH) + ADDR_W'(rp_reg[idx_i]);
                    pipe_vld_next = (fc_reg[idx_i] != '0);
                    pipe_way_next = idx_i;
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else if (!pipe_vld_reg)
                begin
                    if (found_reg)
                    begin
                        res_status_next = STAT_OK;
                        res_val_next    = best_val_reg;
                        res_way_next    = WAYF_W'(best_way_reg);
                        rp_next[best_way_reg] = (rp_reg[best_way_reg] == PTR_W'(DEPTH - 1))
                                                ? '0 : rp_reg[best_way_reg] + PTR_W'(1);
                        fc_next[best_way_reg] = fc_reg[best_way_reg] - FILL_W'(1);
                    end
                    else
                    begin
                        res_status_next = STAT_EMPTY;
                    end
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            way_store[mem_waddr] <= in_value;
        end
        mem_q_reg <= way_store[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pipe_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            for (int i = 0; i < WAYS; i++)
            begin
                rp_reg[i] <= '0;
                fc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            pipe_vld_reg <= pipe_vld_next;
            out_vld_reg  <= out_vld_next;
            rp_reg       <= rp_next;
            fc_reg       <= fc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pipe_way_reg   <= pipe_way_next;
        found_reg      <= found_next;
        best_val_reg   <= best_val_next;
        best_way_reg   <= best_way_next;
        res_status_reg <= res_status_next;
        res_val_reg    <= res_val_next;
        res_way_reg    <= res_way_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_val_reg    <= res_val_reg;
            out_way_reg    <= res_way_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_DATA_W'({out_way_reg, out_val_reg});

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_in_use_reg <= WAYS_IN_USE_RESET;
        end
        else if (cfg_wr && (reg_idx_t'(paddr[2]) == REG_WAYS_IN_USE))
        begin
            ways_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (reg_idx_t'(paddr[2]) == REG_WAYS_IN_USE) ? APB_DATA_W'(ways_in_use_reg)
                                                               : '0;

    // An accepted item always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("block stayed idle after an accepted item");

    // A pending head compare only exists during the scan.
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_vld_reg |-> (state_reg == ST_SCAN))
        else $error("head compare pending outside the scan");

    // Results other than a successful pop carry zero payload.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != STAT_OK)) |-> (m_tdata == '0))
        else $error("nonzero payload on a failed command");

    // The output register is reloaded only when its content is free to go.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("pending result overwritten");

    // The way store is written only while idle.
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (accept && (in_cmd == CMD_PUSH)))
        else $error("way store written outside a push");

endmodule

`default_nettype wire
